/* src/pps_pkg.sv */
package pps_pkg;

   localparam int MAG_W = 7;
   localparam int CNT_W = 7;
   localparam int INV_W = 11;
   localparam int ODD_W = 7;
   localparam int PSI_W = 13;

   typedef struct packed {
      logic signed [7:0] element;
      logic              last;
   } req_item_type;

   typedef struct packed {
      logic [INV_W-1:0] inversions;
      logic [ODD_W-1:0] odd_components;
      logic [PSI_W-1:0] psi_score;
      logic             invalid;
   } rsp_item_type;

   // element token moving down the cell chain
   typedef struct packed {
      logic             valid;
      logic             live;
      logic             last;
      logic [MAG_W-1:0] mag;
      logic [CNT_W-1:0] cnt;
      logic             dup;
      logic             bad;
      logic [ODD_W-1:0] odd;
   } token_type;

endpackage

/* src/permutation_psi_score.sv */
// the last element of a sequence passes the front register, the N_MAX cells and the result register
// throughput: one element per cycle unless stalled; each element walks the chain
// of N_MAX cells, one cell per cycle, so the chain length sets the latency
// the whole chain halts while a result is held by rsp_stall
// reset (synchronous, active high) clears the seen bits, counters and all valids
module permutation_psi_score import pps_pkg::*; #(
   parameter int N_MAX = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         en;
   token_type    chain [N_MAX+1];

   logic [INV_W-1:0] inv_ff, inv_in;
   logic             dup_ff, dup_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   token_type        tail;
   logic [INV_W-1:0] inv_sum;
   logic             bad;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   pps_front #(.N_MAX(N_MAX)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_item  (req_item),
      .tok_out  (chain[0])
   );

   for (genvar i = 0; i < N_MAX; i++) begin : g_cell
      pps_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .tok_i (chain[i]),
         .tok_o (chain[i+1])
      );
   end

   assign tail = chain[N_MAX];

   always_comb begin
      inv_sum      = INV_W'(inv_ff + INV_W'(tail.cnt));
      bad          = tail.bad || tail.dup || dup_ff;
      inv_in       = inv_ff;
      dup_in       = dup_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (en) begin
         rsp_valid_in = 1'b0;
         if (tail.valid) begin
            if (tail.last) begin
               inv_in       = '0;
               dup_in       = 1'b0;
               rsp_valid_in = 1'b1;
               if (bad) begin
                  rsp_item_in = '{inversions: '0, odd_components: '0,
                                  psi_score: '0, invalid: 1'b1};
               end else begin
                  rsp_item_in.inversions     = inv_sum;
                  rsp_item_in.odd_components = tail.odd;
                  rsp_item_in.psi_score      = PSI_W'({inv_sum, 1'b0}) + PSI_W'(tail.odd);
                  rsp_item_in.invalid        = 1'b0;
               end
            end else begin
               inv_in = inv_sum;
               dup_in = dup_ff || tail.dup;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff       <= '0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inv_ff       <= inv_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* src/pps_front.sv */
module pps_front import pps_pkg::*; #(
   parameter int N_MAX = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  req_item_type in_item,
   output token_type    tok_out
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0] start_ff, start_in;
   logic [ODD_W-1:0] odd_ff, odd_in;
   logic             err_ff, err_in;
   token_type        tok_ff, tok_in;

   logic [7:0]       mag8;
   logic             bad_mag;
   logic             full;
   logic             err_now;
   logic [CNT_W-1:0] new_count;
   logic [MAG_W-1:0] new_max;
   logic             close;
   logic [ODD_W-1:0] odd_new;

   always_comb begin
      mag8      = in_item.element[7] ? 8'(-in_item.element) : 8'(in_item.element);
      bad_mag   = (mag8 == 8'd0) || (mag8 > 8'(N_MAX));
      full      = (count_ff >= CNT_W'(N_MAX));
      err_now   = err_ff || bad_mag || full;
      new_count = CNT_W'(count_ff + 1'b1);
      new_max   = (mag8[MAG_W-1:0] > max_ff) ? mag8[MAG_W-1:0] : max_ff;
      close     = (CNT_W'(new_max) == new_count);
      odd_new   = (close && (new_count[0] ^ start_ff[0])) ? ODD_W'(odd_ff + 1'b1) : odd_ff;
   end

   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      start_in = start_ff;
      odd_in   = odd_ff;
      err_in   = err_ff;
      if (en && in_valid) begin
         if (in_item.last) begin
            count_in = '0;
            max_in   = '0;
            start_in = '0;
            odd_in   = '0;
            err_in   = 1'b0;
         end else if (!err_now) begin
            count_in = new_count;
            max_in   = new_max;
            start_in = close ? new_count : start_ff;
            odd_in   = odd_new;
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_comb begin
      tok_in = tok_ff;
      if (en) begin
         tok_in.valid = in_valid;
         tok_in.live  = !err_now;
         tok_in.last  = in_item.last;
         tok_in.mag   = mag8[MAG_W-1:0];
         tok_in.cnt   = '0;
         tok_in.dup   = 1'b0;
         tok_in.bad   = err_now || !close;
         tok_in.odd   = odd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_ff       <= '0;
         start_ff     <= '0;
         odd_ff       <= '0;
         err_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         start_ff <= start_in;
         odd_ff   <= odd_in;
         err_ff   <= err_in;
         tok_ff   <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* src/pps_cell.sv */
module pps_cell import pps_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  token_type tok_i,
   output token_type tok_o
);

   localparam logic [MAG_W-1:0] CELL_MAG = MAG_W'(IDX + 1);

   logic      seen_ff, seen_in;
   token_type tok_ff, tok_in;
   logic      hit;
   logic      above;

   always_comb begin
      hit     = tok_i.valid && tok_i.live && (tok_i.mag == CELL_MAG);
      above   = tok_i.valid && tok_i.live && (tok_i.mag < CELL_MAG) && seen_ff;
      seen_in = seen_ff;
      tok_in  = tok_ff;
      if (en) begin
         tok_in = tok_i;
         if (above) begin
            tok_in.cnt = CNT_W'(tok_i.cnt + 1'b1);
         end
         if (hit && seen_ff) begin
            tok_in.dup = 1'b1;
         end
         if (tok_i.valid && tok_i.last) begin
            seen_in = 1'b0;
         end else if (hit) begin
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

/* dv/tb_permutation_psi_score.sv */
module tb_permutation_psi_score;
   import pps_pkg::*;

   localparam int N_MAX = 64;
   localparam int RANDOM_ITEMS = 1700;
   localparam int MAX_REPORTS = 10;

   typedef enum int {
      PERM_SHUFFLED,
      PERM_BLOCKS,
      PERM_IDENTITY,
      PERM_REVERSED
   } perm_shape_e;

   typedef enum int {
      FLAW_ZERO,
      FLAW_RANGE,
      FLAW_REPEAT,
      FLAW_MISSING,
      FLAW_OVERLONG
   } perm_flaw_e;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // scoring state mirrored from the block
   logic [63:0]  seen_bits = '0;
   int           elem_count = 0;
   int           peak_mag = 0;
   int           run_start = 0;
   int           inv_sum = 0;
   int           odd_sum = 0;
   bit           perm_broken = 1'b0;

   rsp_item_type expected_scores[$];
   int           failures = 0;
   int           reports = 0;
   int           items_sent = 0;
   bit           sender_idle_on = 1'b0;
   bit           receiver_idle_on = 1'b0;

   permutation_psi_score #(
      .N_MAX(N_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("permutation_psi_score regression: fail");
      $finish;
   end

   function automatic int idle_cycles(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   task automatic score_element(input req_item_type it);
      logic [7:0]   raw;
      logic [63:0]  upper;
      int           mag;
      rsp_item_type res;
      raw = it.element;
      mag = raw[7] ? 256 - int'(raw) : int'(raw);
      if (!perm_broken) begin
         if (mag == 0 || mag > N_MAX || elem_count >= N_MAX) begin
            perm_broken = 1'b1;
         end else if (seen_bits[mag-1]) begin
            perm_broken = 1'b1;
         end else begin
            upper = (mag < 64) ? ({64{1'b1}} << mag) : '0;
            inv_sum += $countones(seen_bits & upper);
            seen_bits[mag-1] = 1'b1;
            elem_count++;
            if (mag > peak_mag) begin
               peak_mag = mag;
            end
            if (peak_mag == elem_count) begin
               if ((elem_count - run_start) % 2 == 1) begin
                  odd_sum++;
               end
               run_start = elem_count;
            end
         end
      end
      if (it.last) begin
         res = '0;
         if (perm_broken || peak_mag != elem_count) begin
            res.invalid = 1'b1;
         end else begin
            res.inversions = INV_W'(inv_sum);
            res.odd_components = ODD_W'(odd_sum);
            res.psi_score = PSI_W'(2 * inv_sum + odd_sum);
         end
         expected_scores.push_back(res);
         seen_bits = '0;
         elem_count = 0;
         peak_mag = 0;
         run_start = 0;
         inv_sum = 0;
         odd_sum = 0;
         perm_broken = 1'b0;
      end
   endtask

   task automatic send_element(input int value, input bit is_last);
      int           gap;
      req_item_type it;
      gap = idle_cycles(sender_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.element = 8'(value);
      it.last = is_last;
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      score_element(it);
      items_sent++;
   endtask

   task automatic send_sequence(input int vals[$]);
      foreach (vals[i]) begin
         send_element(vals[i], i == vals.size() - 1);
      end
   endtask

   function automatic void shuffle_values(ref int vals[$]);
      int j;
      int t;
      for (int i = vals.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = vals[i];
         vals[i] = vals[j];
         vals[j] = t;
      end
   endfunction

   function automatic void make_perm(input int n, input perm_shape_e shape,
                                     output int vals[$]);
      int blk[$];
      int pos;
      int b;
      vals = {};
      case (shape)
         PERM_SHUFFLED: begin
            for (int k = 1; k <= n; k++) vals.push_back(k);
            shuffle_values(vals);
         end
         PERM_BLOCKS: begin
            pos = 0;
            while (pos < n) begin
               b = $urandom_range(1, 4);
               if (b > n - pos) begin
                  b = n - pos;
               end
               blk = {};
               for (int k = 1; k <= b; k++) blk.push_back(pos + k);
               shuffle_values(blk);
               vals = {vals, blk};
               pos += b;
            end
         end
         PERM_IDENTITY: begin
            for (int k = 1; k <= n; k++) vals.push_back(k);
         end
         default: begin
            for (int k = n; k >= 1; k--) vals.push_back(k);
         end
      endcase
      foreach (vals[i]) begin
         if ($urandom_range(0, 1)) begin
            vals[i] = -vals[i];
         end
      end
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 86) begin
         return $urandom_range(1, 12);
      end else if (r < 96) begin
         return $urandom_range(13, 40);
      end
      return $urandom_range(41, 64);
   endfunction

   function automatic int out_of_range_value();
      case ($urandom_range(0, 2))
         0:       return -128;
         1:       return $urandom_range(65, 127);
         default: return -int'($urandom_range(65, 127));
      endcase
   endfunction

   task automatic test_smallest_permutations();
      send_sequence('{1});
      send_sequence('{-2, 1});
      send_sequence('{2, 3, 1});
      send_sequence('{1, -3, 2});
   endtask

   task automatic test_illegal_magnitudes();
      send_sequence('{0});
      send_sequence('{-128});
      send_sequence('{65});
      send_sequence('{127});
      send_sequence('{-65});
      send_sequence('{0, 1});
   endtask

   task automatic test_repeated_and_missing();
      send_sequence('{1, -1});
      send_sequence('{2});
      send_sequence('{-64});
   endtask

   task automatic test_length_extremes();
      int vals[$];
      make_perm(N_MAX, PERM_REVERSED, vals);
      send_sequence(vals);
      make_perm(N_MAX, PERM_IDENTITY, vals);
      send_sequence(vals);
      vals = {};
      for (int k = N_MAX; k >= 1; k--) vals.push_back(-k);
      send_sequence(vals);
      make_perm(N_MAX, PERM_SHUFFLED, vals);
      vals.push_back(1);
      send_sequence(vals);
   endtask

   task automatic test_random_permutations();
      int         vals[$];
      int         n;
      int         r;
      int         i;
      int         j;
      perm_flaw_e flaw;
      while (items_sent < RANDOM_ITEMS) begin
         case ((items_sent / 250) % 4)
            0: begin sender_idle_on = 1'b0; receiver_idle_on = 1'b0; end
            1: begin sender_idle_on = 1'b1; receiver_idle_on = 1'b0; end
            2: begin sender_idle_on = 1'b0; receiver_idle_on = 1'b1; end
            default: begin sender_idle_on = 1'b1; receiver_idle_on = 1'b1; end
         endcase
         r = $urandom_range(0, 99);
         n = pick_length();
         make_perm(n, perm_shape_e'($urandom_range(0, 3)), vals);
         if (r < 65) begin
            send_sequence(vals);
         end else if (r < 95) begin
            flaw = perm_flaw_e'($urandom_range(0, 4));
            i = $urandom_range(0, n - 1);
            case (flaw)
               FLAW_ZERO:  vals[i] = 0;
               FLAW_RANGE: vals[i] = out_of_range_value();
               FLAW_REPEAT: begin
                  if (n < 2) begin
                     vals.push_back(vals[0]);
                  end else begin
                     do j = $urandom_range(0, n - 1); while (j == i);
                     vals[i] = (vals[i] < 0) ? -(vals[j] < 0 ? -vals[j] : vals[j])
                                             : (vals[j] < 0 ? -vals[j] : vals[j]);
                  end
               end
               FLAW_MISSING: begin
                  foreach (vals[k]) begin
                     if (vals[k] == n) vals[k] = n + 1;
                     else if (vals[k] == -n) vals[k] = -(n + 1);
                  end
               end
               default: begin
                  make_perm(N_MAX, PERM_SHUFFLED, vals);
                  repeat ($urandom_range(1, 3)) vals.push_back($urandom_range(0, 255));
               end
            endcase
            send_sequence(vals);
         end else begin
            vals = {};
            repeat ($urandom_range(1, 5)) vals.push_back($urandom_range(0, 255));
            send_sequence(vals);
         end
      end
   endtask

   // receiver side: randomly chosen free and stalled stretches
   initial begin
      int n;
      forever begin
         n = idle_cycles(receiver_idle_on);
         if (n == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // result transfer check
   always @(posedge clock) begin
      rsp_item_type exp_score;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_scores.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("unexpected result: inv=%0d odd=%0d psi=%0d invalid=%0b",
                        rsp_item.inversions, rsp_item.odd_components,
                        rsp_item.psi_score, rsp_item.invalid);
            end
         end else begin
            exp_score = expected_scores.pop_front();
            if (rsp_item.inversions !== exp_score.inversions
                || rsp_item.odd_components !== exp_score.odd_components
                || rsp_item.psi_score !== exp_score.psi_score
                || rsp_item.invalid !== exp_score.invalid) begin
               failures++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $display("score mismatch: expected inv=%0d odd=%0d psi=%0d invalid=%0b",
                           exp_score.inversions, exp_score.odd_components,
                           exp_score.psi_score, exp_score.invalid);
                  $display("                actual   inv=%0d odd=%0d psi=%0d invalid=%0b",
                           rsp_item.inversions, rsp_item.odd_components,
                           rsp_item.psi_score, rsp_item.invalid);
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_smallest_permutations();
      test_illegal_magnitudes();
      test_repeated_and_missing();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      test_length_extremes();
      test_random_permutations();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (N_MAX + 12) @(posedge clock);
      if (failures == 0) begin
         $display("permutation_psi_score regression: pass");
      end else begin
         $display("permutation_psi_score regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
src/pps_pkg.sv
src/pps_front.sv
src/pps_cell.sv
src/permutation_psi_score.sv
dv/tb_permutation_psi_score.sv
